// ----- hdl/dssa_pkg.sv -----
// Shared types and constants for the dual-stack shared-array unit.
// No dependencies; imported by dssa_outbuf and dual_stack_shared_array_unit.
package dssa_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int ENTRY_W_DEF = 64;
  localparam int VALUE_W     = 64;

  // request codes (in_tuser[1:0])
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_DUMP = 2'd2;

  // status codes (out_tuser[1:0])
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage

// ----- hdl/dssa_ram.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on nothing; no reset on contents.
module dssa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/dssa_outbuf.sv -----
// Output register with skid stage for the result channel.
// Depends on dssa_pkg (res_t).
module dssa_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dssa_pkg::res_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dssa_pkg::res_t dn_data
);

  import dssa_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic up_xfer;

  assign up_ready = !skid_valid_r;
  assign up_xfer  = up_valid && up_ready;
  assign dn_valid = out_valid_r;
  assign dn_data  = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (up_xfer) begin
      if (out_valid_r && !dn_ready) begin
        skid_nxt       = up_data;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = up_data;
        out_valid_nxt = 1'b1;
      end
    end else if (dn_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && dn_ready) |=> (out_valid_r && out_r == $past(skid_r)))
    else $error("skid result not moved to output in order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (dn_valid && !dn_ready) |=> (dn_valid && $stable(dn_data)))
    else $error("stalled result changed before its transfer");
`endif

endmodule

// ----- hdl/dual_stack_shared_array_unit.sv -----
// Two stacks sharing one entry store: lower stack grows up from entry 0,
// upper stack grows down from entry DEPTH-1. Depends on dssa_pkg, dssa_ram
// and dssa_outbuf.
//
// One request is worked on at a time. A push, an overflow, an underflow, an
// empty readout or an unused code finishes in the cycle it is accepted. For a
// pop or a readout, the first read is issued in the cycle after acceptance;
// the store has a single read port with registered read data, and entries
// then stream out one per cycle while the output stage accepts them.
// The next request is accepted once the last result of the current one has
// entered the output stage; a result may still be waiting on out_tready then,
// and a second one is held in a skid register. push_value keeps its low
// ENTRY_WIDTH bits; entry_value is zero-extended to 64 bits.
module dual_stack_shared_array_unit #(
  parameter int DEPTH       = dssa_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = dssa_pkg::ENTRY_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] push_value
  input  logic [2:0]  in_tuser,   // [1:0] req_type, [2] stack_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] entry_value
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last_item
);

  import dssa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] lower_r, lower_nxt;
  logic [CW-1:0] upper_r, upper_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          down_r, down_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;

  logic [1:0]    req;
  logic          sel;
  logic          in_xfer;
  logic [CW:0]   total;
  logic          full;
  logic [CW-1:0] cnt_sel;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic                   rd_issue;
  logic                   emit;

  logic res_valid, res_ready;
  res_t res, dn_res;
  res_t direct_res;
  logic direct_valid;

  assign req     = in_tuser[1:0];
  assign sel     = in_tuser[2];
  assign total   = {1'b0, lower_r} + {1'b0, upper_r};
  assign full    = total >= (CW+1)'(DEPTH);
  assign cnt_sel = sel ? upper_r : lower_r;

  assign in_tready = (state_r == S_IDLE) && res_ready;
  assign in_xfer   = in_tvalid && in_tready;

  assign emit     = rd_pend_r && res_ready;
  assign rd_issue = (state_r == S_READ) && (left_r != '0) && (!rd_pend_r || emit);

  always_comb begin
    state_nxt    = state_r;
    lower_nxt    = lower_r;
    upper_nxt    = upper_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    down_nxt     = down_r;
    rd_pend_nxt  = rd_pend_r;
    rd_last_nxt  = rd_last_r;
    wr_en        = 1'b0;
    wr_addr      = sel ? AW'(CW'(DEPTH - 1) - upper_r) : AW'(lower_r);
    direct_valid = 1'b0;
    direct_res   = '{status: ST_OK, value: '0, last: 1'b1};

    if (in_xfer) begin
      case (req)
        REQ_PUSH: begin
          direct_valid = 1'b1;
          if (full) begin
            direct_res.status = ST_OVERFLOW;
          end else begin
            wr_en = 1'b1;
            if (sel) begin
              upper_nxt = upper_r + 1'b1;
            end else begin
              lower_nxt = lower_r + 1'b1;
            end
          end
        end
        REQ_POP: begin
          if (cnt_sel == '0) begin
            direct_valid      = 1'b1;
            direct_res.status = ST_UNDERFLOW;
          end else begin
            state_nxt = S_READ;
            left_nxt  = CW'(1);
            if (sel) begin
              upper_nxt = upper_r - 1'b1;
              addr_nxt  = AW'(CW'(DEPTH) - upper_r);
            end else begin
              lower_nxt = lower_r - 1'b1;
              addr_nxt  = AW'(lower_r - 1'b1);
            end
          end
        end
        REQ_DUMP: begin
          if (cnt_sel == '0) begin
            direct_valid      = 1'b1;
            direct_res.status = ST_EMPTY;
          end else begin
            state_nxt = S_READ;
            left_nxt  = cnt_sel;
            down_nxt  = sel;
            addr_nxt  = sel ? AW'(DEPTH - 1) : '0;
          end
        end
        default: begin
          // unused request code: dropped, no result
        end
      endcase
    end

    // streaming reads: issue next address while the previous word drains
    if (rd_issue) begin
      addr_nxt    = down_r ? addr_r - 1'b1 : addr_r + 1'b1;
      left_nxt    = left_r - 1'b1;
      rd_last_nxt = (left_r == CW'(1));
      rd_pend_nxt = 1'b1;
    end else if (emit) begin
      rd_pend_nxt = 1'b0;
    end

    if (emit && rd_last_r) begin
      state_nxt = S_IDLE;
    end
  end

  assign res_valid = direct_valid || emit;
  always_comb begin
    if (emit) begin
      res = '{status: ST_OK, value: VALUE_W'(rd_data), last: rd_last_r};
    end else begin
      res = direct_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lower_r   <= '0;
      upper_r   <= '0;
      rd_pend_r <= 1'b0;
      left_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      lower_r   <= lower_nxt;
      upper_r   <= upper_nxt;
      rd_pend_r <= rd_pend_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    down_r    <= down_nxt;
    rd_last_r <= rd_last_nxt;
  end

  dssa_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[ENTRY_WIDTH-1:0]),
    .rd_en   (rd_issue),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  dssa_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up_data  (res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (dn_res)
  );

  assign out_tdata = dn_res.value;
  assign out_tuser = dn_res.status;
  assign out_tlast = dn_res.last;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (CW+1)'(DEPTH))
    else $error("stacks hold more entries than the store");

  a_pend_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_READ))
    else $error("read data pending outside readout");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && req == REQ_PUSH && !full) |=> (total == $past(total) + 1'b1))
    else $error("accepted push did not grow the stacks by one");

  a_no_dual_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(direct_valid && emit))
    else $error("direct result collides with streamed read result");
`endif

endmodule
